// File: rtl/btn_dbnc_pkg.sv
// Shared types and constants for the button debouncer with long-press detection.
// Holds register indexes, event codes, tick counter sizing and the config struct.
// No dependencies.
package btn_dbnc_pkg;

  localparam int TICK_COUNT_WIDTH = 16;
  localparam int CFG_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CMP_WIDTH = (TICK_COUNT_WIDTH > CFG_WIDTH) ? TICK_COUNT_WIDTH : CFG_WIDTH;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BOOT_IGNORE = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG_PRESS = 2'd2;

  localparam logic [CFG_WIDTH-1:0] BOOT_IGNORE_RESET = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET = 16'd30;
  localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd1500;

  typedef logic [TICK_COUNT_WIDTH-1:0] tick_cnt_t;

  typedef enum logic [1:0] {
    EV_NONE,
    EV_SHORT,
    EV_LONG_RUN,
    EV_LONG_STOP
  } press_event_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] boot_ignore_ticks;
    logic [CFG_WIDTH-1:0] debounce_ticks;
    logic [CFG_WIDTH-1:0] long_press_ticks;
  } cfg_t;

  function automatic tick_cnt_t sat_inc(input tick_cnt_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/button_debounce_short_long_press.sv
// Button debouncer with short and long press detection, top level.
// Stage 1 registers each beat; core state and result registers then update together.
// Throughput: one tick beat per cycle while out_stall does not hold the result.
// Reset: synchronous rst empties both stages, clears all counters, sets level to released
// and loads the register reset values. Depends on btn_dbnc_pkg, btn_dbnc_cfg, btn_dbnc_core.
module button_debounce_short_long_press
  import btn_dbnc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       raw_pressed,
  input  logic                       pump_stopped,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 press_event,
  output logic                       pressed_level,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data
);

  cfg_t         cfg;
  logic         s1_valid;
  logic         s1_raw;
  logic         s1_stopped;
  logic         res_free;
  logic         s1_move;
  logic         s1_load;
  press_event_t core_ev;
  logic         core_level;

  btn_dbnc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign res_free = !out_valid || !out_stall;
  assign s1_move = s1_valid && res_free;
  assign in_stall = s1_valid && !res_free;
  assign s1_load = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_raw <= raw_pressed;
      s1_stopped <= pump_stopped;
    end
  end

  btn_dbnc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_move),
    .raw     (s1_raw),
    .stopped (s1_stopped),
    .cfg     (cfg),
    .ev      (core_ev),
    .level   (core_level)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      press_event <= core_ev;
      pressed_level <= core_level;
    end
  end

endmodule

// File: rtl/btn_dbnc_cfg.sv
// Configuration register file for the button debouncer.
// Depends on btn_dbnc_pkg for register indexes and reset values.
module btn_dbnc_cfg
  import btn_dbnc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  output cfg_t                       cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.boot_ignore_ticks <= BOOT_IGNORE_RESET;
      cfg.debounce_ticks <= DEBOUNCE_RESET;
      cfg.long_press_ticks <= LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BOOT_IGNORE: cfg.boot_ignore_ticks <= cfg_data;
        REG_DEBOUNCE:    cfg.debounce_ticks <= cfg_data;
        REG_LONG_PRESS:  cfg.long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/btn_dbnc_core.sv
// Debounce and press classification state, updated once per tick beat.
// Depends on btn_dbnc_pkg for counter types, event codes and the config struct.
module btn_dbnc_core
  import btn_dbnc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic         raw,
  input  logic         stopped,
  input  cfg_t         cfg,
  output press_event_t ev,
  output logic         level
);

  tick_cnt_t boot_elapsed;
  tick_cnt_t since_change;
  tick_cnt_t hold_elapsed;
  logic      last_raw;
  logic      debounced_level;
  logic      long_done;

  tick_cnt_t boot_elapsed_next;
  tick_cnt_t since_change_next;
  tick_cnt_t hold_elapsed_next;
  logic      last_raw_next;
  logic      debounced_level_next;
  logic      long_done_next;

  logic      boot_done;
  tick_cnt_t sc_eff;
  tick_cnt_t hold_eff;

  always_comb begin
    boot_done = CMP_WIDTH'(boot_elapsed) >= CMP_WIDTH'(cfg.boot_ignore_ticks);
    last_raw_next = last_raw;
    debounced_level_next = debounced_level;
    long_done_next = long_done;
    sc_eff = since_change;
    hold_eff = hold_elapsed;
    ev = EV_NONE;
    if (boot_done) begin
      if (raw != last_raw) begin
        last_raw_next = raw;
        sc_eff = '0;
      end
      if (CMP_WIDTH'(sc_eff) >= CMP_WIDTH'(cfg.debounce_ticks)) begin
        if (raw == debounced_level) begin
          if (debounced_level && !long_done &&
              CMP_WIDTH'(hold_elapsed) >= CMP_WIDTH'(cfg.long_press_ticks)) begin
            long_done_next = 1'b1;
            ev = stopped ? EV_LONG_RUN : EV_LONG_STOP;
          end
        end else begin
          debounced_level_next = raw;
          if (raw) begin
            hold_eff = '0;
            long_done_next = 1'b0;
          end else if (!long_done) begin
            ev = EV_SHORT;
          end
        end
      end
    end
    boot_elapsed_next = sat_inc(boot_elapsed);
    since_change_next = sat_inc(sc_eff);
    hold_elapsed_next = sat_inc(hold_eff);
  end

  assign level = debounced_level_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_elapsed <= '0;
      since_change <= '0;
      hold_elapsed <= '0;
      last_raw <= 1'b0;
      debounced_level <= 1'b0;
      long_done <= 1'b0;
    end else if (step) begin
      boot_elapsed <= boot_elapsed_next;
      since_change <= since_change_next;
      hold_elapsed <= hold_elapsed_next;
      last_raw <= last_raw_next;
      debounced_level <= debounced_level_next;
      long_done <= long_done_next;
    end
  end

  a_long_sets_done: assert property (@(posedge clk) disable iff (rst)
    step && (ev == EV_LONG_RUN || ev == EV_LONG_STOP) |=> long_done)
    else $error("long press fired without marking the hold");

  a_boot_freezes_state: assert property (@(posedge clk) disable iff (rst)
    step && !boot_done |=> last_raw == $past(last_raw) &&
      debounced_level == $past(debounced_level) && long_done == $past(long_done))
    else $error("state changed inside the boot window");

  a_boot_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> boot_elapsed >= $past(boot_elapsed))
    else $error("boot counter went backwards");

  a_short_after_press: assert property (@(posedge clk) disable iff (rst)
    step && ev == EV_SHORT |=> !debounced_level && !long_done)
    else $error("short press reported with wrong hold state");

endmodule
